>>> hdl/ilsd_pkg.sv
`timescale 1ns / 1ps
package ilsd_pkg;

   localparam int SET_INDEX_BITS = 6;
   localparam int WAYS           = 16;
   localparam int ADDR_WIDTH     = 48;
   localparam int SIG_WIDTH      = 64;
   localparam int STAMP_WIDTH    = 64;
   localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
   localparam int WIDX           = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAYS_P2        = 1 << WIDX;
   localparam int TREE_A_LEVELS  = WIDX / 2;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      OUT_HIT      = 2'd0,
      OUT_MODIFIED = 2'd1,
      OUT_INSERTED = 2'd2,
      OUT_FLUSHED  = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_WRITE,
      ST_SWEEP,
      ST_FLUSH_DONE
   } back_state_type;

   typedef struct packed {
      logic                  kind;
      logic [ADDR_WIDTH-1:0] pc;
      logic [SIG_WIDTH-1:0]  code_signature;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [3:0] way;
   } rsp_type;

   // One classified word as it travels from the front part to the back part.
   typedef struct packed {
      logic                      flush;
      logic [SET_INDEX_BITS-1:0] set;
      logic [ADDR_WIDTH-1:0]     pc;
      logic [SIG_WIDTH-1:0]      sig;
   } work_type;

   typedef struct packed {
      logic                   valid;
      logic [ADDR_WIDTH-1:0]  tag;
      logic [SIG_WIDTH-1:0]   sig;
      logic [STAMP_WIDTH-1:0] stamp;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic                   present;
      logic [STAMP_WIDTH-1:0] stamp;
      logic [WIDX-1:0]        idx;
   } cand_type;

   // Keeps the left (lower-numbered) candidate on a tie.
   function automatic cand_type pick_older(cand_type a, cand_type b);
      cand_type r;
      if (!b.present || (a.present && (a.stamp <= b.stamp))) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

>>> hdl/ilsd_ram.sv
`timescale 1ns / 1ps
module ilsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ilsd_front.sv
`timescale 1ns / 1ps
module ilsd_front
   import ilsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   output work_type q_item,
   input  logic     q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   work_type           classified;
   logic               push;

   always_comb begin
      classified.flush = req_data.kind;
      classified.set   = req_data.pc[2*SET_INDEX_BITS-1:SET_INDEX_BITS];
      classified.pc    = req_data.pc;
      classified.sig   = req_data.code_signature;
   end

   assign req_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

>>> hdl/ilsd_back.sv
`timescale 1ns / 1ps
module ilsd_back
   import ilsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  work_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   back_state_type              state_ff, state_in;
   work_type                    item_ff;
   logic [SET_INDEX_BITS-1:0]   sweep_ff;
   logic                        sweep_rsp_ff;
   logic [STAMP_WIDTH-1:0]      count_ff;
   row_type                     row_ff;
   logic                        hit_ff;
   logic [WIDX-1:0]             hit_way_ff;
   logic                        inv_any_ff;
   logic [WIDX-1:0]             inv_way_ff;
   cand_type                    cand_ff [WAYS_P2];
   logic                        rsp_valid_ff;
   rsp_type                     rsp_ff;

   row_type                     rdata;
   row_type                     wdata;
   logic                        ram_wr, ram_rd;
   logic [SET_INDEX_BITS-1:0]   ram_addr;
   logic                        out_free;
   logic                        emit;
   rsp_type                     emit_data;
   logic                        count_inc;

   logic                        hit_c;
   logic [WIDX-1:0]             hit_way_c;
   logic                        inv_any_c;
   logic [WIDX-1:0]             inv_way_c;
   cand_type                    tree_a [WAYS_P2];
   cand_type                    tree_b [WAYS_P2];
   logic [WIDX-1:0]             fill_way;
   row_type                     upd_row;
   row_type                     clr_row;

   ilsd_ram #(
      .WIDTH($bits(row_type)),
      .DEPTH(NUM_SETS)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_wr),
      .rd_en(ram_rd),
      .addr (ram_addr),
      .wdata(wdata),
      .rdata(rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Hit search, free-way search and the first levels of the age tree.
   always_comb begin
      hit_c     = 1'b0;
      hit_way_c = '0;
      inv_any_c = 1'b0;
      inv_way_c = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rdata[w].valid && (rdata[w].tag == item_ff.pc)) begin
            hit_c     = 1'b1;
            hit_way_c = WIDX'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!rdata[w].valid) begin
            inv_any_c = 1'b1;
            inv_way_c = WIDX'(w);
         end
      end
      for (int n = 0; n < WAYS_P2; n++) begin
         tree_a[n].present = (n < WAYS);
         tree_a[n].stamp   = (n < WAYS) ? rdata[n % WAYS].stamp : '0;
         tree_a[n].idx     = WIDX'(n);
      end
      for (int l = 0; l < TREE_A_LEVELS; l++) begin
         for (int n = 0; n < (WAYS_P2 >> (l + 1)); n++) begin
            tree_a[n] = pick_older(tree_a[2*n], tree_a[2*n+1]);
         end
      end
   end

   // Remaining tree levels, then the way to fill and the updated row.
   always_comb begin
      for (int n = 0; n < WAYS_P2; n++) begin
         tree_b[n] = cand_ff[n];
      end
      for (int l = TREE_A_LEVELS; l < WIDX; l++) begin
         for (int n = 0; n < (WAYS_P2 >> (l + 1)); n++) begin
            tree_b[n] = pick_older(tree_b[2*n], tree_b[2*n+1]);
         end
      end
      fill_way = inv_any_ff ? inv_way_ff : tree_b[0].idx;
      upd_row  = row_ff;
      if (hit_ff) begin
         upd_row[hit_way_ff].stamp = count_ff;
      end else begin
         upd_row[fill_way].valid = 1'b1;
         upd_row[fill_way].tag   = item_ff.pc;
         upd_row[fill_way].sig   = item_ff.sig;
         upd_row[fill_way].stamp = count_ff;
      end
      for (int w = 0; w < WAYS; w++) begin
         clr_row[w].valid = 1'b0;
         clr_row[w].tag   = '0;
         clr_row[w].sig   = '0;
         clr_row[w].stamp = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = q_item.flush ? ST_SWEEP : ST_READ;
            end
         end
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_ff == SET_INDEX_BITS'(NUM_SETS - 1)) begin
               state_in = sweep_rsp_ff ? ST_FLUSH_DONE : ST_IDLE;
            end
         end
         ST_FLUSH_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      ram_wr    = 1'b0;
      ram_rd    = 1'b0;
      ram_addr  = item_ff.set;
      wdata     = upd_row;
      emit      = 1'b0;
      emit_data = '0;
      count_inc = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = q_valid;
         ST_READ: ram_rd = 1'b1;
         ST_EVAL: ;
         ST_WRITE: begin
            if (out_free) begin
               ram_wr            = 1'b1;
               emit              = 1'b1;
               count_inc         = 1'b1;
               emit_data.outcome = hit_ff ?
                  ((row_ff[hit_way_ff].sig == item_ff.sig) ? OUT_HIT : OUT_MODIFIED) :
                  OUT_INSERTED;
               emit_data.way     = hit_ff ? 4'(hit_way_ff) : 4'(fill_way);
            end
         end
         ST_SWEEP: begin
            ram_wr   = 1'b1;
            ram_addr = sweep_ff;
            wdata    = clr_row;
         end
         ST_FLUSH_DONE: begin
            if (out_free) begin
               emit              = 1'b1;
               emit_data.outcome = OUT_FLUSHED;
               emit_data.way     = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SWEEP) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (q_pop) begin
            sweep_ff     <= '0;
            sweep_rsp_ff <= 1'b1;
         end
         if (count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_EVAL) begin
         row_ff     <= rdata;
         hit_ff     <= hit_c;
         hit_way_ff <= hit_way_c;
         inv_any_ff <= inv_any_c;
         inv_way_ff <= inv_way_c;
         for (int n = 0; n < WAYS_P2; n++) begin
            cand_ff[n] <= tree_a[n];
         end
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr && ram_rd)) else $error("set memory read and written together");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_data.outcome != OUT_FLUSHED)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("access counter did not advance");
   a_flush_way: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_data.outcome == OUT_FLUSHED)) |-> (emit_data.way == '0))
      else $error("flush reported a way");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("result overwritten before taken");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE)) else $error("word taken while busy");

endmodule

>>> hdl/icache_lru_smc_detector_top.sv
`timescale 1ns / 1ps
// Instruction cache tag model that flags self-modifying code.
// Input words (req_) carry an access (pc and instruction signature) or a
// flush of the whole cache. Every input word yields exactly one result word
// (rsp_): hit unchanged, hit with modified code, miss inserted, or flushed.
// The front part classifies words into a two-word queue; the back part
// works on one word at a time against a set memory holding one row per set.
// An access passes four steps in the back part: queue pop, set read, hit
// search with the first age-tree levels, then the last tree levels with the
// row write back, which also loads the result register. The back part takes
// no new word until the write is done. A flush is popped from the queue, then
// rewrites every set, one row per cycle, then registers its result.
// After reset the same sweep clears all 64 sets of the set memory; input words
// are queued meanwhile (up to two) and processed after it.
// When the receiver holds rsp_ready low, the result stays in the output
// register; the back part stops before its next write or flush result, and
// the queue keeps taking input words until it is full.
module icache_lru_smc_detector_top
   import ilsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     q_valid;
   work_type q_item;
   logic     q_pop;

   ilsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ilsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
class cache_scoreboard;
   bit              valid_q [ilsd_pkg::NUM_SETS][ilsd_pkg::WAYS];
   bit [47:0]       tag_q   [ilsd_pkg::NUM_SETS][ilsd_pkg::WAYS];
   bit [63:0]       sig_q   [ilsd_pkg::NUM_SETS][ilsd_pkg::WAYS];
   bit [63:0]       stamp_q [ilsd_pkg::NUM_SETS][ilsd_pkg::WAYS];
   bit [63:0]       access_count;
   ilsd_pkg::rsp_type expected_rsps[$];
   int              errors;

   function void clear_state();
      foreach (valid_q[s, w]) begin
         valid_q[s][w] = 0;
         stamp_q[s][w] = 0;
      end
      access_count = 0;
   endfunction

   function void report_error(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction

   function void note_request(ilsd_pkg::req_type req);
      ilsd_pkg::rsp_type rsp;
      int set_idx;
      int free_way;
      int old_way;
      bit [63:0] old_stamp;
      bit hit;
      free_way = -1;
      old_way = 0;
      hit = 0;
      if (req.kind) begin
         foreach (valid_q[s, w]) begin
            valid_q[s][w] = 0;
            stamp_q[s][w] = access_count;
         end
         rsp.outcome = ilsd_pkg::OUT_FLUSHED;
         rsp.way = 0;
      end else begin
         set_idx = req.pc[11:6];
         old_stamp = stamp_q[set_idx][0];
         for (int w = 0; w < ilsd_pkg::WAYS && !hit; w++) begin
            if (!valid_q[set_idx][w]) free_way = w;
            if (stamp_q[set_idx][w] < old_stamp) begin
               old_stamp = stamp_q[set_idx][w];
               old_way = w;
            end
            if (valid_q[set_idx][w] && tag_q[set_idx][w] == req.pc) begin
               hit = 1;
               stamp_q[set_idx][w] = access_count;
               rsp.outcome = (sig_q[set_idx][w] == req.code_signature) ?
                             ilsd_pkg::OUT_HIT : ilsd_pkg::OUT_MODIFIED;
               rsp.way = 4'(w);
            end
         end
         if (!hit) begin
            if (free_way < 0) free_way = old_way;
            valid_q[set_idx][free_way] = 1;
            tag_q[set_idx][free_way] = req.pc;
            sig_q[set_idx][free_way] = req.code_signature;
            stamp_q[set_idx][free_way] = access_count;
            rsp.outcome = ilsd_pkg::OUT_INSERTED;
            rsp.way = 4'(free_way);
         end
         access_count++;
      end
      expected_rsps.push_back(rsp);
   endfunction

   function void check_result(ilsd_pkg::rsp_type got);
      ilsd_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_error("unexpected result word");
         return;
      end
      want = expected_rsps.pop_front();
      if (got.outcome !== want.outcome)
         report_error($sformatf("outcome %0d, wanted %0d", got.outcome, want.outcome));
      if (got.way !== want.way)
         report_error($sformatf("way %0d, wanted %0d", got.way, want.way));
   endfunction
endclass

module testbench;
   import ilsd_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   cache_scoreboard tracker;
   bit [47:0] hot_pcs[32];

   icache_lru_smc_detector_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("testbench failed");
      $finish;
   end

   // Result side: random stall pattern, plus one long hold-off while the
   // sender keeps offering words.
   initial begin
      int pattern;
      int cycle_n;
      rsp_ready = 0;
      pattern = 0;
      cycle_n = 0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         if (cycle_n >= 1000 && cycle_n < 1300) rsp_ready <= 0;
         else if (pattern < 200) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
         pattern = (pattern + 1) % 600;
         cycle_n++;
      end
   end

   task automatic send_word(input req_type req);
      req_valid <= 1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(req);
   endtask

   task automatic access(input bit [47:0] pc, input bit [63:0] sig);
      req_type req;
      req.kind = 0;
      req.pc = pc;
      req.code_signature = sig;
      send_word(req);
   endtask

   task automatic flush_all(input bit [47:0] pc, input bit [63:0] sig);
      req_type req;
      req.kind = 1;
      req.pc = pc;
      req.code_signature = sig;
      send_word(req);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic bit [47:0] pc_in_set(input bit [5:0] set_idx);
      bit [47:0] pc;
      pc = 48'({$urandom, $urandom});
      pc[11:6] = set_idx;
      return pc;
   endfunction

   initial begin
      int burst;
      int choice;
      tracker = new();
      tracker.clear_state();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed: extremes, two hits, a modified hit, and a flush.
      access('0, '0);
      access('1, '1);
      access('0, '0);
      access('0, 64'h1);
      access('1, '1);
      flush_all('1, '1);
      access('1, '0);
      // Fill set 5 beyond its ways so the oldest way gets replaced.
      for (int i = 0; i < 18; i++) access({36'(i + 1), 6'd5, 6'(i)}, 64'(i));
      idle_gap(3);

      for (int i = 0; i < 32; i++) hot_pcs[i] = pc_in_set(6'($urandom_range(0, 3)));

      for (int n = 0; n < 800; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++, n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 60) begin
               // Reuse a small pool so hits, modified code and evictions occur.
               access(hot_pcs[$urandom_range(0, 31)], 64'($urandom_range(0, 1)));
            end else if (choice < 98) begin
               access(48'({$urandom, $urandom}), {$urandom, $urandom});
            end else begin
               flush_all(48'({$urandom, $urandom}), {$urandom, $urandom});
            end
         end
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 8));
      end
      req_valid <= 0;

      while (tracker.expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_rsps.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/ilsd_pkg.sv
hdl/ilsd_ram.sv
hdl/ilsd_front.sv
hdl/ilsd_back.sv
hdl/icache_lru_smc_detector_top.sv
bench/testbench.sv
